// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the DFU request block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ===== rtl/dfu_pkg.sv =====
// Types, codes and helper functions of the DFU request block.
`default_nettype none

package dfu_pkg;

    // Opcodes of the incoming item.
    typedef enum logic [3:0] {
        OP_GETSTATUS = 4'd0,
        OP_GETSTATE  = 4'd1,
        OP_DNLOAD    = 4'd2,
        OP_UPLOAD    = 4'd3,
        OP_CLRSTATUS = 4'd4,
        OP_OTHER     = 4'd5,
        OP_PAYLOAD   = 4'd6,
        OP_FLASHDONE = 4'd7,
        OP_MANIFEST  = 4'd8
    } t_op;

    // Internal protocol state, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SYNC     = 6'b000010,
        ST_BUSY     = 6'b000100,
        ST_DLIDLE   = 6'b001000,
        ST_MANIFEST = 6'b010000,
        ST_ERROR    = 6'b100000
    } t_state;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_APP_BASE   = 2'd0,
        CFG_FLASH_END  = 2'd1,
        CFG_POLL_ERASE = 2'd2,
        CFG_POLL_PROG  = 2'd3
    } t_cfg_idx;

    // DFU state codes as reported to the host.
    localparam logic [3:0] DFU_IDLE     = 4'd2;
    localparam logic [3:0] DFU_SYNC     = 4'd3;
    localparam logic [3:0] DFU_BUSY     = 4'd4;
    localparam logic [3:0] DFU_DLIDLE   = 4'd5;
    localparam logic [3:0] DFU_MANIFEST = 4'd7;
    localparam logic [3:0] DFU_ERROR    = 4'd10;

    // Status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_VERIFY  = 2'd1;
    localparam logic [1:0] STAT_ADDRESS = 2'd2;

    // Transport actions.
    localparam logic [1:0] ACT_ACK     = 2'd0;
    localparam logic [1:0] ACT_REPLY   = 2'd1;
    localparam logic [1:0] ACT_CAPTURE = 2'd2;

    // Reply sources.
    localparam logic [1:0] SRC_STATUS = 2'd0;
    localparam logic [1:0] SRC_STATE  = 2'd1;
    localparam logic [1:0] SRC_FLASH  = 2'd2;

    localparam logic [7:0] MANIFEST_POLL  = 8'd100;
    localparam logic [6:0] STATUS_REC_LEN = 7'd6;

    // Configuration reset values.
    localparam logic [31:0] APP_BASE_RST   = 32'd4096;
    localparam logic [31:0] FLASH_END_RST  = 32'd16384;
    localparam logic [7:0]  POLL_ERASE_RST = 8'd5;
    localparam logic [7:0]  POLL_PROG_RST  = 8'd2;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [15:0] block_number;
        logic [15:0] request_length;
        logic        image_valid;
    } t_req;

    typedef struct packed {
        logic [1:0]  action;
        logic [6:0]  reply_len;
        logic [1:0]  reply_source;
        logic [1:0]  status_code;
        logic [3:0]  dfu_state;
        logic [7:0]  poll_ms;
        logic [31:0] mem_addr;
        logic        flash_go;
        logic [6:0]  write_len;
        logic        reboot;
    } t_res;

    // Maps the one-hot state to the code the host sees.
    function automatic logic [3:0] state_code(input t_state s);
        case (s)
            ST_IDLE:     state_code = DFU_IDLE;
            ST_SYNC:     state_code = DFU_SYNC;
            ST_BUSY:     state_code = DFU_BUSY;
            ST_DLIDLE:   state_code = DFU_DLIDLE;
            ST_MANIFEST: state_code = DFU_MANIFEST;
            default:     state_code = DFU_ERROR;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dfu_if.sv =====
// Valid/ready channel interfaces for requests and results of the DFU block.
`default_nettype none

interface dfu_req_if;
    logic           valid;
    logic           ready;
    dfu_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dfu_res_if;
    logic           valid;
    logic           ready;
    dfu_pkg::t_res  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dfu_request_state_machine.sv =====
// Top level of the USB DFU 1.1 device-side request state machine.
//
// Usage: decoded DFU class requests and local events (payload captured,
// flash write done, manifest check) arrive as items on the i_req channel.
// Each accepted item produces exactly one result item on o_res, carrying
// the transport action, reply length and source, memory address, flash
// write start with its byte count, and a reboot strobe.
// The result is registered at the edge that accepts the item. One item
// is taken every cycle while the output side drains and no remainder
// pause runs. When PAGE_BYTES is not a power of two, a download that sets
// a new block address starts a two-stage reciprocal remainder unit that
// holds i_req.ready low while it runs; with a power-of-two page size no pause occurs.
// If the receiver stalls, one more result is held in a skid register and
// i_req.ready drops only once both output registers are full.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_wdata) writes the flash window
// and poll timeouts; the user must write it only while the block is idle (not enforced).
// Synchronous reset returns the block to dfuIDLE with status OK, no
// pending block, and the configuration registers at their defaults.
`default_nettype none
`include "assert_macros.svh"

module dfu_request_state_machine #(
    parameter int BLOCK_BYTES = 64,
    parameter int PAGE_BYTES  = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dfu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                    i_cfg_wdata,
    dfu_req_if.sink                        i_req,
    dfu_res_if.source                      o_res
);

    localparam bit PAGE_POW2 = ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0);
    localparam int PAGE_W    = $clog2(PAGE_BYTES);

    // Configuration registers.
    logic [31:0] r_app_base;
    logic [31:0] r_flash_end;
    logic [7:0]  r_poll_erase;
    logic [7:0]  r_poll_prog;

    // Protocol state and its next values.
    dfu_pkg::t_state r_state, n_state;
    logic [1:0]      r_status, n_status;
    logic [7:0]      r_poll, n_poll;
    logic [31:0]     r_pend_addr, n_pend_addr;
    logic [6:0]      r_pend_cnt, n_pend_cnt;
    logic            r_flash_armed, n_flash_armed;
    logic            r_man_armed, n_man_armed;
    logic            r_pay_ready, n_pay_ready;

    // True when the pending block address is page aligned.
    logic            r_aligned;

    dfu_pkg::t_req   req;
    dfu_pkg::t_res   n_res;
    logic            acc;
    logic            skid_ready;
    logic            rem_busy;
    logic            ld_block;

    // Address arithmetic, kept one or two bits wider than 32 so that the
    // guard compares never wrap.
    logic [32:0]     blk_off;
    logic [32:0]     addr;
    logic [33:0]     blk_end;
    logic [33:0]     flash_end_x;
    logic [15:0]     up_n;
    logic [33:0]     up_end;
    logic [32:0]     up_room;
    logic [15:0]     up_len;
    logic            dn_bad;

    assign req         = i_req.data;
    assign i_req.ready = skid_ready && !rem_busy;
    assign acc         = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app_base   <= dfu_pkg::APP_BASE_RST;
            r_flash_end  <= dfu_pkg::FLASH_END_RST;
            r_poll_erase <= dfu_pkg::POLL_ERASE_RST;
            r_poll_prog  <= dfu_pkg::POLL_PROG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dfu_pkg::CFG_APP_BASE:   r_app_base   <= i_cfg_wdata;
                dfu_pkg::CFG_FLASH_END:  r_flash_end  <= i_cfg_wdata;
                dfu_pkg::CFG_POLL_ERASE: r_poll_erase <= i_cfg_wdata[7:0];
                dfu_pkg::CFG_POLL_PROG:  r_poll_prog  <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Block address and the window checks of download and upload.
    always_comb begin
        blk_off     = 33'(req.block_number) * 33'(BLOCK_BYTES);
        addr        = {1'b0, r_app_base} + blk_off;
        blk_end     = {1'b0, addr} + 34'(BLOCK_BYTES);
        flash_end_x = {2'b00, r_flash_end};
        dn_bad      = (req.request_length > 16'(BLOCK_BYTES)) || (blk_end > flash_end_x);

        up_n    = (req.request_length < 16'(BLOCK_BYTES)) ? req.request_length
                                                           : 16'(BLOCK_BYTES);
        up_end  = {1'b0, addr} + 34'(up_n);
        up_room = {1'b0, r_flash_end} - addr;
        if (addr >= {1'b0, r_flash_end}) begin
            up_len = '0;
        end else if (up_end > flash_end_x) begin
            // Clipped reads are shorter than a block, so the low bits suffice.
            up_len = up_room[15:0];
        end else begin
            up_len = up_n;
        end
    end

    // One step of the request state machine.
    always_comb begin
        n_state       = r_state;
        n_status      = r_status;
        n_poll        = r_poll;
        n_pend_addr   = r_pend_addr;
        n_pend_cnt    = r_pend_cnt;
        n_flash_armed = r_flash_armed;
        n_man_armed   = r_man_armed;
        n_pay_ready   = r_pay_ready;
        n_res         = '0;
        ld_block      = 1'b0;

        case (req.opcode)
            dfu_pkg::OP_GETSTATUS: begin
                // GETSTATUS in dnload-sync arms the pending block and reports busy.
                if (r_state == dfu_pkg::ST_SYNC && r_pend_addr != '0) begin
                    n_status      = dfu_pkg::STAT_OK;
                    n_poll        = r_aligned ? r_poll_erase : r_poll_prog;
                    n_state       = dfu_pkg::ST_BUSY;
                    n_flash_armed = !r_pay_ready;
                    if (r_pay_ready) begin
                        n_pay_ready     = 1'b0;
                        n_res.flash_go  = 1'b1;
                        n_res.mem_addr  = r_pend_addr;
                        n_res.write_len = r_pend_cnt;
                    end
                end
                n_res.action       = dfu_pkg::ACT_REPLY;
                n_res.reply_len    = (req.request_length < 16'(dfu_pkg::STATUS_REC_LEN))
                                     ? req.request_length[6:0] : dfu_pkg::STATUS_REC_LEN;
                n_res.reply_source = dfu_pkg::SRC_STATUS;
            end
            dfu_pkg::OP_GETSTATE: begin
                n_res.action       = dfu_pkg::ACT_REPLY;
                n_res.reply_len    = {6'd0, (req.request_length != '0)};
                n_res.reply_source = dfu_pkg::SRC_STATE;
            end
            dfu_pkg::OP_DNLOAD: begin
                if (req.request_length != '0) begin
                    if (dn_bad) begin
                        n_status = dfu_pkg::STAT_ADDRESS;
                        n_state  = dfu_pkg::ST_ERROR;
                    end else begin
                        n_flash_armed = 1'b0;
                        n_pay_ready   = 1'b0;
                        n_pend_addr   = addr[31:0];
                        n_pend_cnt    = req.request_length[6:0];
                        n_state       = dfu_pkg::ST_SYNC;
                        n_res.action  = dfu_pkg::ACT_CAPTURE;
                        ld_block      = 1'b1;
                    end
                end else begin
                    // A zero-length download ends the image and enters manifest.
                    n_status    = dfu_pkg::STAT_OK;
                    n_poll      = dfu_pkg::MANIFEST_POLL;
                    n_state     = dfu_pkg::ST_MANIFEST;
                    n_man_armed = 1'b1;
                end
            end
            dfu_pkg::OP_UPLOAD: begin
                n_res.action       = dfu_pkg::ACT_REPLY;
                n_res.reply_len    = up_len[6:0];
                n_res.reply_source = dfu_pkg::SRC_FLASH;
                n_res.mem_addr     = addr[31:0];
            end
            dfu_pkg::OP_CLRSTATUS: begin
                n_status      = dfu_pkg::STAT_OK;
                n_poll        = '0;
                n_state       = dfu_pkg::ST_IDLE;
                n_pend_addr   = '0;
                n_flash_armed = 1'b0;
                n_man_armed   = 1'b0;
                n_pay_ready   = 1'b0;
            end
            dfu_pkg::OP_PAYLOAD: begin
                if ((r_state inside {dfu_pkg::ST_SYNC, dfu_pkg::ST_BUSY})
                        && r_pend_addr != '0) begin
                    n_pay_ready   = !r_flash_armed;
                    n_flash_armed = 1'b0;
                    if (r_flash_armed) begin
                        n_res.flash_go  = 1'b1;
                        n_res.mem_addr  = r_pend_addr;
                        n_res.write_len = r_pend_cnt;
                    end
                end
            end
            dfu_pkg::OP_FLASHDONE: begin
                if (r_state == dfu_pkg::ST_BUSY && !r_flash_armed) begin
                    n_pend_addr = '0;
                    n_status    = dfu_pkg::STAT_OK;
                    n_poll      = '0;
                    n_state     = dfu_pkg::ST_DLIDLE;
                end
            end
            dfu_pkg::OP_MANIFEST: begin
                if (r_man_armed) begin
                    n_man_armed = 1'b0;
                    if (req.image_valid) begin
                        n_res.reboot = 1'b1;
                    end else begin
                        n_status = dfu_pkg::STAT_VERIFY;
                        n_state  = dfu_pkg::ST_ERROR;
                    end
                end
            end
            default: begin
                // Other and undefined requests are acknowledged without change.
            end
        endcase

        n_res.status_code = n_status;
        n_res.dfu_state   = dfu_pkg::state_code(n_state);
        n_res.poll_ms     = n_poll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dfu_pkg::ST_IDLE;
            r_status      <= dfu_pkg::STAT_OK;
            r_poll        <= '0;
            r_pend_addr   <= '0;
            r_pend_cnt    <= '0;
            r_flash_armed <= 1'b0;
            r_man_armed   <= 1'b0;
            r_pay_ready   <= 1'b0;
        end else if (acc) begin
            r_state       <= n_state;
            r_status      <= n_status;
            r_poll        <= n_poll;
            r_pend_addr   <= n_pend_addr;
            r_pend_cnt    <= n_pend_cnt;
            r_flash_armed <= n_flash_armed;
            r_man_armed   <= n_man_armed;
            r_pay_ready   <= n_pay_ready;
        end
    end

    // Page alignment of the pending block, needed by the next GETSTATUS.
    generate
        if (PAGE_POW2) begin : g_align_mask
            assign rem_busy = 1'b0;

            always_ff @(posedge i_clk) begin
                if (acc && ld_block) begin
                    r_aligned <= (addr[PAGE_W-1:0] == '0);
                end
            end
        end else begin : g_align_recip
            // Scaled reciprocal of the page size; the quotient taken from it is
            // exact for every 32-bit address.
            localparam logic [32:0] RECIP = 33'(((64'd1 << (32 + PAGE_W))
                                                 + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES));

            logic        r_rem_s1;
            logic        r_rem_s2;
            logic [31:0] r_rem_x;
            logic [31:0] r_rem_q;
            logic [64:0] rem_prod;

            assign rem_busy = r_rem_s1 || r_rem_s2;
            assign rem_prod = 65'(r_rem_x) * 65'(RECIP);

            // First stage forms the quotient, second compares its multiple
            // of the page size with the address.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rem_s1 <= 1'b0;
                    r_rem_s2 <= 1'b0;
                end else begin
                    r_rem_s1 <= acc && ld_block;
                    r_rem_s2 <= r_rem_s1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (acc && ld_block) begin
                    r_rem_x <= addr[31:0];
                end
                if (r_rem_s1) begin
                    r_rem_q <= 32'(rem_prod >> (32 + PAGE_W));
                end
                if (r_rem_s2) begin
                    r_aligned <= (32'(r_rem_q * 32'(PAGE_BYTES)) == r_rem_x);
                end
            end
        end
    endgenerate

    dfu_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_item  (n_res),
        .o_ready (skid_ready),
        .o_res   (o_res)
    );

    `ASSERT_IMPLY(a_go_in_busy, i_clk, i_rst_n, acc && n_res.flash_go,
                  n_res.dfu_state == dfu_pkg::DFU_BUSY)
    `ASSERT_IMPLY(a_reboot_armed, i_clk, i_rst_n, acc && n_res.reboot,
                  r_man_armed && !n_man_armed)
    `ASSERT_CLK(a_capture_sync, i_clk, i_rst_n,
                acc && n_res.action == dfu_pkg::ACT_CAPTURE |=> r_state == dfu_pkg::ST_SYNC)

endmodule

`default_nettype wire

// ===== rtl/dfu_skid.sv =====
// Two-entry output register with skid stage for the DFU result channel.
`default_nettype none
`include "assert_macros.svh"

module dfu_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dfu_pkg::t_res i_item,
    output logic          o_ready,
    dfu_res_if.source     o_res
);

    logic          r_main_v;
    logic          r_skid_v;
    dfu_pkg::t_res r_main;
    dfu_pkg::t_res r_skid;
    logic          take;

    assign take        = r_main_v && o_res.ready;
    assign o_ready     = !r_skid_v;
    assign o_res.valid = r_main_v;
    assign o_res.data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (i_push) begin
            if (r_main_v) begin
                r_skid_v <= 1'b1;
            end else begin
                r_main_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_v) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_item;
            end
        end else if (i_push) begin
            if (r_main_v) begin
                r_skid <= i_item;
            end else begin
                r_main <= i_item;
            end
        end
    end

    `ASSERT_IMPLY(a_skid_needs_main, i_clk, i_rst_n, r_skid_v, r_main_v)
    `ASSERT_CLK(a_push_has_room, i_clk, i_rst_n, i_push |-> !r_skid_v)
    `ASSERT_CLK(a_hold_on_stall, i_clk, i_rst_n,
                o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.data))

endmodule

`default_nettype wire
